[hw/rtl/wcn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcn_pkg
// Shared types and codes for the waveform capture normaliser.
// ----------------------------------------------------------------------------
package wcn_pkg;

  // request function codes (tuser on the input side)
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_FREEZE = 2'd1;
  localparam logic [1:0] FUNC_COLUMN = 2'd2;

  // result kinds (tuser on the output side)
  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_RING_LEN = 2'd1;
  localparam logic [1:0] CFG_WINDOW   = 2'd2;
  localparam logic [1:0] CFG_HEIGHT   = 2'd3;

  // shared divider: 27-bit magnitude dividend, 16-bit divisor
  localparam int DIV_W  = 27;
  localparam int DEN_W  = 16;
  localparam int DCNT_W = 5;

  // peak at or below this is not used as divisor
  localparam logic [15:0] PEAK_FLOOR = 16'd3;
  localparam logic [15:0] FULL_SCALE = 16'h8000;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FRZ,
    S_COL_MUL,
    S_COL_LD,
    S_DIV,
    S_MONO_WR,
    S_ROW,
    S_RESP
  } state_t;

endpackage

[hw/rtl/waveform_capture_normalizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_capture_normalizer
// Averages interleaved channel samples into a ring memory, freezes a window
// into a snapshot memory with its peak, and maps columns to display rows.
// ----------------------------------------------------------------------------
// A channel sample that does not close a frame is only accumulated; one
// that closes a frame runs the 27-step serial divider and then the ring write.
// Freeze walks the window with one ring read per cycle; a column read runs a
// multiply, the shared 27-step divider and a row step. One request at a
// time. After reset the ring memory is zeroed address by address, during
// which no request is taken; configuration writes are taken at all times.
module waveform_capture_normalizer
  import wcn_pkg::*;
#(
  parameter int RING_DEPTH   = 8192,
  parameter int WINDOW_MAX   = 2048,
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample[15:0], column[26:16], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // peak_level[15:0], row[28:16], bad_column[29]
  output logic        m_tuser,   // kind[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wdata
);

  localparam int RA_W   = $clog2(RING_DEPTH);
  localparam int LEN_W  = RA_W + 1;
  localparam int WA_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WC_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = $clog2(MAX_CHANNELS) + 17;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);

  // memories
  logic signed [15:0] ring_mem [RING_DEPTH];
  logic signed [15:0] snap_mem [WINDOW_MAX];
  logic signed [15:0] ring_q;
  logic signed [15:0] snap_q;
  logic               ring_we;
  logic [RA_W-1:0]    ring_waddr;
  logic signed [15:0] ring_wdata;
  logic               snap_we;

  // control and state
  state_t state, state_next;
  logic [RA_W-1:0]    clr_addr;
  logic [3:0]         reg_ch;
  logic [13:0]        reg_len;
  logic [11:0]        reg_win;
  logic [12:0]        reg_ht;
  logic [RA_W-1:0]    wpos;
  logic signed [SUM_W-1:0] ch_sum;
  logic [CNT_W-1:0]   ch_seen;
  logic [15:0]        frozen_peak;

  // freeze walk
  logic [RA_W-1:0]    frz_addr;
  logic [WC_W-1:0]    frz_iss;
  logic [WA_W-1:0]    frz_wr_idx;
  logic               frz_rd_v;
  logic [15:0]        peak_acc;

  // column path
  logic               col_bad;
  logic signed [28:0] prod;

  // serial divider
  logic [DIV_W-1:0]   div_quo;
  logic [DEN_W:0]     div_rem;
  logic [DEN_W-1:0]   div_den;
  logic               div_neg;
  logic [DCNT_W-1:0]  div_cnt;
  logic               op_col;

  // response holding
  logic               rsp_kind;
  logic [15:0]        rsp_peak;
  logic [12:0]        rsp_row;
  logic               rsp_bad;

  // request fields
  logic               accept;
  logic [1:0]         in_func;
  logic signed [15:0] in_sample;
  logic [10:0]        in_col;

  // derived values
  logic [CNT_W-1:0]   eff_ch;
  logic [LEN_W-1:0]   eff_len;
  logic [WC_W-1:0]    eff_win;
  logic [RA_W-1:0]    eff_pos;
  logic [RA_W-1:0]    pos_adv;
  logic [LEN_W:0]     frz_start;
  logic [RA_W-1:0]    frz_addr_nx;
  logic signed [SUM_W-1:0] sum_in;
  logic [SUM_W-1:0]   sum_mag;
  logic [CNT_W-1:0]   seen_inc;
  logic               frame_done;
  logic [15:0]        ring_mag;
  logic               frz_done;
  logic [11:0]        half;
  logic [DEN_W:0]     rem_sh;
  logic               rem_ge;
  logic [DEN_W:0]     rem_nx;
  logic signed [15:0] mono;
  logic signed [28:0] q_s;
  logic signed [28:0] row_s;
  logic [12:0]        row_sat;
  logic [27:0]        prod_mag;
  logic               out_free;

  assign accept    = s_tvalid && s_tready;
  assign in_func   = s_tuser;
  assign in_sample = signed'(s_tdata[15:0]);
  assign in_col    = s_tdata[26:16];
  assign half      = reg_ht[12:1];
  assign out_free  = !m_tvalid || m_tready;

  // clamp configuration to usable ranges
  always_comb begin
    logic [31:0] w;
    logic [31:0] c;
    c = 32'(reg_ch);
    if (c == 32'd0) c = 32'd1;
    if (c > 32'(MAX_CHANNELS)) c = 32'(MAX_CHANNELS);
    eff_ch = CNT_W'(c);
    if (reg_len == 14'd0) eff_len = LEN_W'(1);
    else if (32'(reg_len) > 32'(RING_DEPTH)) eff_len = LEN_W'(RING_DEPTH);
    else eff_len = LEN_W'(reg_len);
    w = 32'(reg_win);
    if (w > 32'(eff_len)) w = 32'(eff_len);
    if (w > 32'(WINDOW_MAX)) w = 32'(WINDOW_MAX);
    eff_win = WC_W'(w);
  end

  assign eff_pos = ({1'b0, wpos} >= eff_len) ? '0 : wpos;
  assign pos_adv = (LEN_W'(eff_pos) + LEN_W'(1) >= eff_len) ? '0 : eff_pos + RA_W'(1);

  // oldest window entry: (pos + len - n) mod len
  always_comb begin
    frz_start = {1'b0, LEN_W'(eff_pos)} + {1'b0, eff_len} - (LEN_W + 1)'(eff_win);
    if (frz_start >= {1'b0, eff_len}) frz_start = frz_start - {1'b0, eff_len};
  end
  assign frz_addr_nx = (LEN_W'(frz_addr) + LEN_W'(1) >= eff_len) ? '0 : frz_addr + RA_W'(1);

  // frame accumulation
  assign sum_in     = ch_sum + SUM_W'(in_sample);
  assign sum_mag    = sum_in[SUM_W-1] ? unsigned'(-sum_in) : unsigned'(sum_in);
  assign seen_inc   = ch_seen + CNT_W'(1);
  assign frame_done = (seen_inc >= eff_ch);

  assign ring_mag = ring_q[15] ? unsigned'(-ring_q) : unsigned'(ring_q);
  assign frz_done = (frz_iss == eff_win) && !frz_rd_v;

  // one restoring divider step
  assign rem_sh = {div_rem[DEN_W-1:0], div_quo[DIV_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_den});
  assign rem_nx = rem_ge ? rem_sh - {1'b0, div_den} : rem_sh;

  assign mono = div_neg ? -signed'(div_quo[15:0]) : signed'(div_quo[15:0]);

  // row = half - q, saturated to 0..2*half
  assign prod_mag = prod[28] ? 28'(unsigned'(-prod)) : 28'(unsigned'(prod));
  assign q_s   = div_neg ? -signed'({2'b00, div_quo}) : signed'({2'b00, div_quo});
  assign row_s = signed'({17'd0, half}) - q_s;
  always_comb begin
    if (row_s < 0) row_sat = '0;
    else if (row_s > signed'({16'd0, half, 1'b0})) row_sat = {half, 1'b0};
    else row_sat = row_s[12:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (clr_addr == RA_W'(RING_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_SAMPLE: if (frame_done) state_next = S_DIV;
            FUNC_FREEZE: state_next = S_FRZ;
            FUNC_COLUMN: state_next = (11'(in_col) < 11'(eff_win) || WC_W > 11)
                                      && (32'(in_col) < 32'(eff_win))
                                      ? S_COL_MUL : S_RESP;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_FRZ:     if (frz_done) state_next = S_RESP;
      S_COL_MUL: state_next = S_COL_LD;
      S_COL_LD:  state_next = S_DIV;
      S_DIV:     if (div_cnt == DCNT_W'(DIV_W - 1)) state_next = op_col ? S_ROW : S_MONO_WR;
      S_MONO_WR: state_next = S_IDLE;
      S_ROW:     state_next = S_RESP;
      S_RESP:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs and memory strobes
  always_comb begin
    s_tready   = 1'b0;
    ring_we    = 1'b0;
    ring_waddr = eff_pos;
    ring_wdata = mono;
    snap_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = clr_addr;
        ring_wdata = '0;
      end
      S_IDLE:    s_tready = 1'b1;
      S_FRZ:     snap_we  = frz_rd_v;
      S_MONO_WR: ring_we  = 1'b1;
      default:   s_tready = 1'b0;
    endcase
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    ring_q <= ring_mem[frz_addr];
  end

  // snapshot memory
  always_ff @(posedge clk) begin
    if (snap_we) snap_mem[frz_wr_idx] <= ring_q;
    snap_q <= snap_mem[WA_W'(in_col)];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_ch  <= 4'd2;
      reg_len <= 14'd8192;
      reg_win <= 12'd1200;
      reg_ht  <= 13'd400;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNELS: reg_ch  <= cfg_wdata[3:0];
        CFG_RING_LEN: reg_len <= cfg_wdata;
        CFG_WINDOW:   reg_win <= cfg_wdata[11:0];
        CFG_HEIGHT:   reg_ht  <= cfg_wdata[12:0];
        default:      reg_ch  <= reg_ch;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      wpos        <= '0;
      ch_sum      <= '0;
      ch_seen     <= '0;
      frozen_peak <= '0;
      m_tvalid    <= 1'b0;
      frz_rd_v    <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready && state != S_RESP) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + RA_W'(1);
        S_IDLE: begin
          if (accept && in_func == FUNC_SAMPLE) begin
            if (frame_done) begin
              ch_sum  <= '0;
              ch_seen <= '0;
            end else begin
              ch_sum  <= sum_in;
              ch_seen <= seen_inc;
            end
          end
          frz_rd_v <= 1'b0;
        end
        S_FRZ: begin
          // issue one ring read a cycle, write back the previous one
          frz_rd_v <= (frz_iss < eff_win);
          if (frz_done) frozen_peak <= peak_acc;
        end
        S_MONO_WR: wpos <= pos_adv;
        S_RESP:    if (out_free) m_tvalid <= 1'b1;
        default:   frz_rd_v <= 1'b0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        frz_addr <= RA_W'(frz_start);
        frz_iss  <= '0;
        peak_acc <= '0;
        if (accept && in_func == FUNC_SAMPLE) begin
          div_quo <= DIV_W'(sum_mag);
          div_rem <= '0;
          div_den <= DEN_W'(eff_ch);
          div_neg <= sum_in[SUM_W-1];
          div_cnt <= '0;
          op_col  <= 1'b0;
        end
        if (accept && in_func == FUNC_FREEZE) begin
          rsp_kind <= KIND_PEAK;
          rsp_row  <= '0;
          rsp_bad  <= 1'b0;
        end
        if (accept && in_func == FUNC_COLUMN) begin
          // out-of-window column answers the centre line
          rsp_kind <= KIND_ROW;
          rsp_peak <= frozen_peak;
          rsp_row  <= {1'b0, half};
          rsp_bad  <= 1'b1;
          col_bad  <= 1'b1;
        end
      end
      S_FRZ: begin
        if (frz_iss < eff_win) begin
          frz_wr_idx <= frz_iss[WA_W-1:0];
          frz_iss    <= frz_iss + WC_W'(1);
          frz_addr   <= frz_addr_nx;
        end
        if (frz_rd_v && ring_mag > peak_acc) peak_acc <= ring_mag;
        if (frz_done) rsp_peak <= peak_acc;
      end
      S_COL_MUL: begin
        prod    <= snap_q * signed'({1'b0, half});
        col_bad <= 1'b0;
      end
      S_COL_LD: begin
        div_quo <= DIV_W'(prod_mag);
        div_rem <= '0;
        div_den <= (frozen_peak > PEAK_FLOOR) ? frozen_peak : FULL_SCALE;
        div_neg <= prod[28];
        div_cnt <= '0;
        op_col  <= 1'b1;
      end
      S_DIV: begin
        div_rem <= rem_nx;
        div_quo <= {div_quo[DIV_W-2:0], rem_ge};
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      S_ROW: begin
        rsp_row <= row_sat;
        rsp_bad <= col_bad;
      end
      S_RESP: begin
        if (out_free) begin
          m_tuser <= rsp_kind;
          m_tdata <= {2'b00, rsp_bad, rsp_row, rsp_peak};
        end
      end
      default: div_cnt <= div_cnt;
    endcase
  end

endmodule
